/* design/bimodal_branch_predictor_top_assert.svh */
// assertion macros for the bimodal predictor
`ifndef BIMODAL_BRANCH_PREDICTOR_TOP_ASSERT_SVH
`define BIMODAL_BRANCH_PREDICTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BBP_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define BBP_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BBP_CHECK(label, prop, msg)
`define BBP_CHECK_NEXT(label, ante, cons, msg)
`endif
`endif

/* design/bbp_pkg.sv */
`default_nettype none
package bbp_pkg;

	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int PC_W = 32;
	localparam int WORD_W = 30;
	localparam int COUNT_W = 32;
	localparam logic [1:0] CTR_WEAK_NT = 2'd1;

	typedef enum logic [1:0] {
		OP_PREDICT = 2'd0,
		OP_COMMIT  = 2'd1,
		OP_SYNC    = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]      opcode;
		logic [PC_W-1:0] branch_pc;
		logic            was_predicted_taken;
		logic            was_taken;
	} req_t;

	typedef struct packed {
		logic               predict_taken;
		logic [COUNT_W-1:0] total_branches;
		logic [COUNT_W-1:0] correct_branches;
	} rsp_t;

	// stage load enables
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} pipe_ctrl_t;

	typedef struct packed {
		logic       we;
		logic [1:0] val;
	} tbl_wr_t;

	function automatic int slot_width(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage
`default_nettype wire

/* design/bbp_index.sv */
`default_nettype none
module bbp_index #(
	parameter int TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                                          clk,
	input  wire bbp_pkg::pipe_ctrl_t                           ctrl,
	input  wire logic [bbp_pkg::WORD_W-1:0]                    word,
	output logic [bbp_pkg::slot_width(TABLE_ENTRIES)-1:0]      slot_s3,
	output logic [bbp_pkg::slot_width(TABLE_ENTRIES)-1:0]      slot_s4
);
	localparam int SLOT_W = bbp_pkg::slot_width(TABLE_ENTRIES);
	localparam int WORD_W = bbp_pkg::WORD_W;
	localparam int LOG2 = $clog2(TABLE_ENTRIES);
	localparam int SHIFT = WORD_W + LOG2;
	localparam int RECIP_W = WORD_W + 1;
	localparam int PROD_W = SHIFT + WORD_W;
	localparam longint unsigned RECIP =
		((longint'(1) << SHIFT) + longint'(TABLE_ENTRIES) - 1) / longint'(TABLE_ENTRIES);

	logic [WORD_W-1:0] word_s1;
	logic [WORD_W-1:0] word_s2;
	logic [WORD_W-1:0] quot_s2;
	logic [PROD_W-1:0] prod;
	logic [WORD_W-1:0] qn;
	logic [WORD_W-1:0] rem;

	// quotient by reciprocal multiply, exact for 30-bit words
	assign prod = PROD_W'(word_s1) * PROD_W'(RECIP_W'(RECIP));
	assign qn = quot_s2 * WORD_W'(TABLE_ENTRIES);
	assign rem = word_s2 - qn;

	always_ff @(posedge clk) begin
		if (ctrl.ld_s1) begin
			word_s1 <= word;
		end
		if (ctrl.ld_s2) begin
			word_s2 <= word_s1;
			quot_s2 <= prod[PROD_W-1:SHIFT];
		end
		if (ctrl.ld_s3) begin
			slot_s3 <= rem[SLOT_W-1:0];
		end
		if (ctrl.ld_s4) begin
			slot_s4 <= slot_s3;
		end
	end

endmodule
`default_nettype wire

/* design/bbp_table.sv */
`default_nettype none
module bbp_table #(
	parameter int TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     ld_s4,
	input  wire logic [bbp_pkg::slot_width(TABLE_ENTRIES)-1:0] rd_slot,
	input  wire bbp_pkg::tbl_wr_t                         wr,
	input  wire logic [bbp_pkg::slot_width(TABLE_ENTRIES)-1:0] wr_slot,
	output logic [1:0]                                    counter_s4,
	output logic                                          clear_done
);
	localparam int SLOT_W = bbp_pkg::slot_width(TABLE_ENTRIES);
	localparam logic [SLOT_W-1:0] LAST = SLOT_W'(TABLE_ENTRIES - 1);

	logic [1:0]        mem [TABLE_ENTRIES];
	logic [1:0]        rdata_s4;
	logic [1:0]        fwd_val_s4;
	logic              fwd_s4;
	logic              clr_busy_q;
	logic [SLOT_W-1:0] clr_idx_q;

	assign clear_done = !clr_busy_q;
	assign counter_s4 = fwd_s4 ? fwd_val_s4 : rdata_s4;

	// initialisation sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == LAST) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s4 <= 1'b0;
		end else if (ld_s4) begin
			fwd_s4 <= wr.we && (wr_slot == rd_slot);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= bbp_pkg::CTR_WEAK_NT;
		end else if (wr.we) begin
			mem[wr_slot] <= wr.val;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			rdata_s4 <= mem[rd_slot];
			fwd_val_s4 <= wr.val;
		end
	end

endmodule
`default_nettype wire

/* design/bbp_state.sv */
`default_nettype none
module bbp_state #(
	parameter int TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          exec,
	input  wire logic [1:0]                                    opcode_s4,
	input  wire logic                                          pred_s4,
	input  wire logic                                          actual_s4,
	input  wire logic [bbp_pkg::slot_width(TABLE_ENTRIES)-1:0] slot_s4,
	input  wire logic [1:0]                                    counter_s4,
	output bbp_pkg::rsp_t                                      result,
	output bbp_pkg::tbl_wr_t                                   wr,
	output logic [bbp_pkg::slot_width(TABLE_ENTRIES)-1:0]      wr_slot
);
	localparam int SLOT_W = bbp_pkg::slot_width(TABLE_ENTRIES);
	localparam int COUNT_W = bbp_pkg::COUNT_W;

	logic               pend_valid_q;
	logic [SLOT_W-1:0]  pend_slot_q;
	logic [1:0]         pend_ctr_q;
	logic [COUNT_W-1:0] total_com_q;
	logic [COUNT_W-1:0] correct_com_q;
	logic [COUNT_W-1:0] total_pend_q;
	logic [COUNT_W-1:0] correct_pend_q;
	logic [1:0]         stepped;
	logic [COUNT_W-1:0] total_inc;
	logic [COUNT_W-1:0] correct_inc;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	always_comb begin
		if (actual_s4) begin
			stepped = (counter_s4 == 2'd3) ? counter_s4 : counter_s4 + 2'd1;
		end else begin
			stepped = (counter_s4 == 2'd0) ? counter_s4 : counter_s4 - 2'd1;
		end
	end

	assign total_inc = sat_inc(total_com_q);
	assign correct_inc = (pred_s4 == actual_s4) ? sat_inc(correct_com_q) : correct_com_q;

	assign wr.we = exec && (opcode_s4 == bbp_pkg::OP_SYNC) && pend_valid_q;
	assign wr.val = pend_ctr_q;
	assign wr_slot = pend_slot_q;

	always_comb begin
		result.predict_taken = 1'b0;
		result.total_branches = total_com_q;
		result.correct_branches = correct_com_q;
		case (opcode_s4)
			bbp_pkg::OP_PREDICT: begin
				result.predict_taken = counter_s4[1];
			end
			bbp_pkg::OP_SYNC: begin
				result.total_branches = total_pend_q;
				result.correct_branches = correct_pend_q;
			end
			default: begin
				result.predict_taken = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_slot_q <= '0;
			pend_ctr_q <= bbp_pkg::CTR_WEAK_NT;
			total_com_q <= '0;
			correct_com_q <= '0;
			total_pend_q <= '0;
			correct_pend_q <= '0;
		end else if (exec) begin
			case (opcode_s4)
				bbp_pkg::OP_COMMIT: begin
					pend_valid_q <= 1'b1;
					pend_slot_q <= slot_s4;
					pend_ctr_q <= stepped;
					total_pend_q <= total_inc;
					correct_pend_q <= correct_inc;
				end
				bbp_pkg::OP_SYNC: begin
					total_com_q <= total_pend_q;
					correct_com_q <= correct_pend_q;
				end
				default: begin
					pend_valid_q <= pend_valid_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* design/bimodal_branch_predictor_top.sv */
// bimodal two-bit counter branch predictor
// a request beat passes the two-step slot divide, the registered table read and the
// answer register before its answer beat is offered
// throughput: one beat per cycle while rsp_ready is high, the counter table has one read and one write port
// reset: asynchronous; afterwards req_ready stays low until every counter
// has been set to weakly not taken
`default_nettype none
`include "bimodal_branch_predictor_top_assert.svh"
module bimodal_branch_predictor_top #(
	parameter int TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire bbp_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output bbp_pkg::rsp_t      rsp
);
	localparam int SLOT_W = bbp_pkg::slot_width(TABLE_ENTRIES);

	bbp_pkg::pipe_ctrl_t ctrl;
	bbp_pkg::tbl_wr_t    wr;
	bbp_pkg::rsp_t       result;

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic [1:0]        opcode_s1, opcode_s2, opcode_s3, opcode_s4;
	logic              pred_s1, pred_s2, pred_s3, pred_s4;
	logic              actual_s1, actual_s2, actual_s3, actual_s4;
	logic              rsp_valid_q;
	bbp_pkg::rsp_t     rsp_q;
	logic              ld_out;
	logic              exec;
	logic              accept;
	logic              clear_done;
	logic [SLOT_W-1:0] slot_s3;
	logic [SLOT_W-1:0] slot_s4;
	logic [SLOT_W-1:0] wr_slot;
	logic [1:0]        counter_s4;
	logic              pipe_busy;
	logic              exec_other;
	logic              count_order;

	// bubbles collapse, a stage loads when it is empty or the next one is empty or moving
	assign ld_out = !rsp_valid_q || rsp_ready;
	assign ctrl.ld_s4 = !valid_s4 || ld_out;
	assign ctrl.ld_s3 = !valid_s3 || ctrl.ld_s4;
	assign ctrl.ld_s2 = !valid_s2 || ctrl.ld_s3;
	assign ctrl.ld_s1 = !valid_s1 || ctrl.ld_s2;
	assign req_ready = clear_done && ctrl.ld_s1;
	assign accept = req_valid && req_ready;
	assign exec = valid_s4 && ld_out;

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign pipe_busy = valid_s1 || valid_s2 || valid_s3 || valid_s4 || rsp_valid_q;
	assign exec_other = exec && (opcode_s4 != bbp_pkg::OP_PREDICT);
	assign count_order = rsp_q.correct_branches <= rsp_q.total_branches;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctrl.ld_s1) begin
				valid_s1 <= accept;
			end
			if (ctrl.ld_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ctrl.ld_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ctrl.ld_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ld_out) begin
				rsp_valid_q <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s1) begin
			opcode_s1 <= req.opcode;
			pred_s1 <= req.was_predicted_taken;
			actual_s1 <= req.was_taken;
		end
		if (ctrl.ld_s2) begin
			opcode_s2 <= opcode_s1;
			pred_s2 <= pred_s1;
			actual_s2 <= actual_s1;
		end
		if (ctrl.ld_s3) begin
			opcode_s3 <= opcode_s2;
			pred_s3 <= pred_s2;
			actual_s3 <= actual_s2;
		end
		if (ctrl.ld_s4) begin
			opcode_s4 <= opcode_s3;
			pred_s4 <= pred_s3;
			actual_s4 <= actual_s3;
		end
		if (exec) begin
			rsp_q <= result;
		end
	end

	bbp_index #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_index (
		.clk     (clk),
		.ctrl    (ctrl),
		.word    (req.branch_pc[bbp_pkg::PC_W-1:2]),
		.slot_s3 (slot_s3),
		.slot_s4 (slot_s4)
	);

	bbp_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld_s4      (ctrl.ld_s4),
		.rd_slot    (slot_s3),
		.wr         (wr),
		.wr_slot    (wr_slot),
		.counter_s4 (counter_s4),
		.clear_done (clear_done)
	);

	bbp_state #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.exec       (exec),
		.opcode_s4  (opcode_s4),
		.pred_s4    (pred_s4),
		.actual_s4  (actual_s4),
		.slot_s4    (slot_s4),
		.counter_s4 (counter_s4),
		.result     (result),
		.wr         (wr),
		.wr_slot    (wr_slot)
	);

	`BBP_CHECK(a_clear_empty, !clear_done |-> !pipe_busy, "pipeline busy during initialisation")
	`BBP_CHECK_NEXT(a_other_not_taken, exec_other, !rsp_q.predict_taken, "taken on non-lookup beat")
	`BBP_CHECK(a_correct_le_total, rsp_valid_q |-> count_order, "correct count above total count")

endmodule
`default_nettype wire

/* sim/bimodal_branch_predictor_top_test.sv */
module bimodal_branch_predictor_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF;
	localparam int SLOT_W = bbp_pkg::slot_width(TABLE_ENTRIES);
	localparam int COUNT_W = bbp_pkg::COUNT_W;
	localparam int PC_W = bbp_pkg::PC_W;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_BEATS = 1450;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	bbp_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	bbp_pkg::rsp_t rsp;

	// branch history as the block should hold it
	logic [1:0] ctr_tbl [TABLE_ENTRIES];
	logic pend_valid;
	int pend_slot;
	logic [1:0] pend_ctr;
	logic [COUNT_W-1:0] total_comm, correct_comm, total_pend, correct_pend;

	bbp_pkg::rsp_t answer_fifo [$];
	int fault_count;
	int beats_sent;
	int op_count [4];
	int answers_seen;
	int taken_answers;
	int deepest_backlog;
	int cycle_count;

	bit tx_idle_on;
	bit rx_idle_on;
	int hold_request;
	int rx_hold_left;
	int rx_stall_left;

	int hot_slot [8];
	logic hot_bias [8];

	bimodal_branch_predictor_top #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic int idle_gap();
		return int'(($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3));
	endfunction

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic bbp_pkg::req_t beat_of(input bbp_pkg::op_t op,
			input logic [PC_W-1:0] pc, input logic guessed, input logic went);
		bbp_pkg::req_t b;
		b.opcode = op;
		b.branch_pc = pc;
		b.was_predicted_taken = guessed;
		b.was_taken = went;
		return b;
	endfunction

	task automatic advance_predictor(input bbp_pkg::req_t beat, output bbp_pkg::rsp_t outcome);
		int slot;
		logic [1:0] c;
		slot = int'((beat.branch_pc >> 2) % TABLE_ENTRIES);
		c = ctr_tbl[slot];
		outcome = '0;
		case (beat.opcode)
			bbp_pkg::OP_PREDICT: begin
				outcome.predict_taken = c[1];
			end
			bbp_pkg::OP_COMMIT: begin
				total_pend = bump(total_comm);
				correct_pend = (beat.was_predicted_taken == beat.was_taken) ?
					bump(correct_comm) : correct_comm;
				pend_slot = slot;
				if (beat.was_taken)
					pend_ctr = (c == 2'd3) ? c : c + 2'd1;
				else
					pend_ctr = (c == 2'd0) ? c : c - 2'd1;
				pend_valid = 1'b1;
			end
			bbp_pkg::OP_SYNC: begin
				if (pend_valid)
					ctr_tbl[pend_slot] = pend_ctr;
				total_comm = total_pend;
				correct_comm = correct_pend;
			end
			default: ;
		endcase
		outcome.total_branches = total_comm;
		outcome.correct_branches = correct_comm;
	endtask

	always @(posedge clk) begin
		bbp_pkg::rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				advance_predictor(req, want);
				answer_fifo.push_back(want);
				op_count[req.opcode]++;
				if (answer_fifo.size() > deepest_backlog)
					deepest_backlog = answer_fifo.size();
			end
			if (rsp_valid && rsp_ready) begin
				if (answer_fifo.size() == 0) begin
					$display("%t: answer beat with nothing outstanding", $time);
					fault_count++;
				end else begin
					want = answer_fifo.pop_front();
					answers_seen++;
					taken_answers += int'(rsp.predict_taken);
					if (rsp.predict_taken !== want.predict_taken) begin
						$display("%t: predict_taken expected %0d got %0d", $time,
							want.predict_taken, rsp.predict_taken);
						fault_count++;
					end
					if (rsp.total_branches !== want.total_branches) begin
						$display("%t: total_branches expected %0d got %0d", $time,
							want.total_branches, rsp.total_branches);
						fault_count++;
					end
					if (rsp.correct_branches !== want.correct_branches) begin
						$display("%t: correct_branches expected %0d got %0d", $time,
							want.correct_branches, rsp.correct_branches);
						fault_count++;
					end
				end
			end
		end
	end

	// answer side: random stalls plus an occasional long hold-off
	initial begin
		rsp_ready = 1'b0;
		rx_hold_left = 0;
		rx_stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				rx_hold_left = hold_request;
				hold_request = 0;
			end
			if (rx_hold_left != 0) begin
				rsp_ready <= 1'b0;
				rx_hold_left--;
			end else if (rx_stall_left != 0) begin
				rsp_ready <= 1'b0;
				rx_stall_left--;
			end else begin
				rsp_ready <= 1'b1;
				if (rx_idle_on && $urandom_range(0, 4) == 0)
					rx_stall_left = idle_gap();
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("bimodal_branch_predictor_top_test NOT OK");
		$finish;
	end

	task automatic send_beat(input bbp_pkg::req_t item);
		int gap;
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		beats_sent++;
		if (tx_idle_on && $urandom_range(0, 2) == 0) begin
			gap = idle_gap();
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle_answers();
		req_valid <= 1'b0;
		@(posedge clk);
		while (answer_fifo.size() != 0)
			@(posedge clk);
	endtask

	// lookup, resolve, then usually publish
	task automatic send_branch_round();
		logic [PC_W-1:0] pc;
		int k;
		logic guess;
		logic went;
		k = int'($urandom_range(0, 7));
		pc = $urandom();
		if ($urandom_range(0, 7) != 0)
			pc[SLOT_W+1:2] = hot_slot[k][SLOT_W-1:0];
		send_beat(beat_of(bbp_pkg::OP_PREDICT, pc, coin(), coin()));
		guess = ctr_tbl[int'((pc >> 2) % TABLE_ENTRIES)][1];
		if ($urandom_range(0, 3) == 0)
			guess = coin();
		went = ($urandom_range(0, 4) == 0) ? ~hot_bias[k] : hot_bias[k];
		send_beat(beat_of(bbp_pkg::OP_COMMIT, pc, guess, went));
		if ($urandom_range(0, 7) == 0)
			send_beat(beat_of(bbp_pkg::OP_COMMIT, $urandom(), coin(), coin()));
		if ($urandom_range(0, 9) != 0)
			send_beat(beat_of(bbp_pkg::OP_SYNC, $urandom(), coin(), coin()));
		if ($urandom_range(0, 5) == 0)
			send_beat(beat_of(bbp_pkg::OP_SYNC, $urandom(), coin(), coin()));
	endtask

	task automatic test_cold_state();
		send_beat(beat_of(bbp_pkg::OP_PREDICT, 32'h0000_0000, 1'b0, 1'b0));
		send_beat(beat_of(bbp_pkg::OP_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1));
		send_beat(beat_of(bbp_pkg::OP_SYNC, 32'hFFFF_FFFF, 1'b1, 1'b0));
		send_beat(beat_of(bbp_pkg::OP_NOP, 32'hFFFF_FFFF, 1'b1, 1'b1));
		send_beat(beat_of(bbp_pkg::OP_NOP, 32'h0000_0000, 1'b0, 1'b0));
		settle_answers();
	endtask

	task automatic test_counter_walk();
		send_beat(beat_of(bbp_pkg::OP_COMMIT, 32'hFFFF_FFFF, 1'b0, 1'b1));
		send_beat(beat_of(bbp_pkg::OP_SYNC, 32'h0, 1'b0, 1'b0));
		send_beat(beat_of(bbp_pkg::OP_COMMIT, 32'hFFFF_FFFF, 1'b1, 1'b1));
		send_beat(beat_of(bbp_pkg::OP_SYNC, 32'h0, 1'b0, 1'b0));
		send_beat(beat_of(bbp_pkg::OP_COMMIT, 32'hFFFF_FFFF, 1'b1, 1'b1));
		send_beat(beat_of(bbp_pkg::OP_SYNC, 32'h0, 1'b0, 1'b0));
		send_beat(beat_of(bbp_pkg::OP_PREDICT, 32'hFFFF_FFFC, 1'b0, 1'b0));
		settle_answers();
	endtask

	task automatic test_commit_replace();
		send_beat(beat_of(bbp_pkg::OP_COMMIT, 32'h0000_0010, 1'b0, 1'b1));
		send_beat(beat_of(bbp_pkg::OP_COMMIT, 32'h0000_0014, 1'b0, 1'b0));
		send_beat(beat_of(bbp_pkg::OP_SYNC, 32'h0, 1'b0, 1'b0));
		send_beat(beat_of(bbp_pkg::OP_SYNC, 32'h0, 1'b0, 1'b0));
		send_beat(beat_of(bbp_pkg::OP_PREDICT, 32'h0000_0010, 1'b0, 1'b0));
		send_beat(beat_of(bbp_pkg::OP_PREDICT, 32'h0000_0014, 1'b0, 1'b0));
		settle_answers();
	endtask

	task automatic test_alias_floor();
		send_beat(beat_of(bbp_pkg::OP_COMMIT, 32'h0000_0000, 1'b0, 1'b0));
		send_beat(beat_of(bbp_pkg::OP_SYNC, 32'h0, 1'b0, 1'b0));
		send_beat(beat_of(bbp_pkg::OP_COMMIT, 32'h1234_5003, 1'b1, 1'b0));
		send_beat(beat_of(bbp_pkg::OP_SYNC, 32'h0, 1'b0, 1'b0));
		send_beat(beat_of(bbp_pkg::OP_PREDICT, 32'hFFFF_F000, 1'b0, 1'b0));
		settle_answers();
	endtask

	task automatic test_random_traffic(input int target);
		int i;
		while (beats_sent < target) begin
			if ($urandom_range(0, 30) == 0) begin
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 20) == 0) begin
				i = int'($urandom_range(0, 7));
				hot_bias[i] = ~hot_bias[i];
			end
			if ($urandom_range(0, 9) == 0)
				send_beat(beat_of(bbp_pkg::op_t'($urandom_range(0, 3)), $urandom(),
					coin(), coin()));
			else
				send_branch_round();
		end
		settle_answers();
	endtask

	task automatic test_output_backpressure();
		tx_idle_on = 1'b0;
		hold_request = 300;
		repeat (12) send_branch_round();
		settle_answers();
		tx_idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_request = 0;
		fault_count = 0;
		beats_sent = 0;
		answers_seen = 0;
		taken_answers = 0;
		deepest_backlog = 0;
		foreach (op_count[i])
			op_count[i] = 0;
		foreach (ctr_tbl[i])
			ctr_tbl[i] = bbp_pkg::CTR_WEAK_NT;
		pend_valid = 1'b0;
		pend_slot = 0;
		pend_ctr = bbp_pkg::CTR_WEAK_NT;
		total_comm = '0;
		correct_comm = '0;
		total_pend = '0;
		correct_pend = '0;
		hot_slot[0] = 0;
		hot_slot[1] = TABLE_ENTRIES - 1;
		for (int i = 2; i < 8; i++)
			hot_slot[i] = int'($urandom_range(0, TABLE_ENTRIES - 1));
		foreach (hot_bias[i])
			hot_bias[i] = coin();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_cold_state();
		test_counter_walk();
		test_commit_replace();
		test_alias_floor();
		test_random_traffic(RANDOM_BEATS / 2);
		test_output_backpressure();
		test_random_traffic(RANDOM_BEATS);

		repeat (10) @(posedge clk);
		$display("covered %0d request beats: %0d lookups, %0d commits, %0d syncs, %0d no-ops",
			beats_sent, op_count[bbp_pkg::OP_PREDICT], op_count[bbp_pkg::OP_COMMIT],
			op_count[bbp_pkg::OP_SYNC], op_count[bbp_pkg::OP_NOP]);
		$display("%0d answers compared (%0d taken), deepest backlog %0d beats",
			answers_seen, taken_answers, deepest_backlog);
		if (fault_count == 0 && answer_fifo.size() == 0) begin
			$display("bimodal_branch_predictor_top_test OK");
		end else begin
			$display("%0d mismatches, %0d answers outstanding", fault_count,
				answer_fifo.size());
			$display("bimodal_branch_predictor_top_test NOT OK");
		end
		$finish;
	end

endmodule
